// File: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types for the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W       = 64;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

endpackage

// File: rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Sorted free-region table with first-fit allocate and coalescing release.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | tuser
// s_      | in  | addr[31:0], size[63:32]                          | op
// m_      | out | result_addr[31:0], free_total[63:32],            | status
//         |     | entries_used[72:64], peak_entries[81:73],        |
//         |     | lost_count[113:82], lost_bytes[145:114], zero pad|
// An item runs from accept to the next accept through a scan of the entries
// in use, a shift when one is needed, and the wait on m_tready: the table
// RAM has one read port, so the scan and the shift visit one entry at a time.
// Reset empties the table at once (count only).
// s_tready is low while an item is in work or its result waits on m_.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // addr[31:0], size[63:32]
    input  logic          s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata,   // result_addr, free_total, entries_used,
                                     // peak_entries, lost_count, lost_bytes
    output logic [1:0]    m_tuser    // status
);
    import ffa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_EVAL  = 8'b0000_0100,
        S_SHRD  = 8'b0000_1000,
        S_SHWR  = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_NEXT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic              op_reg;
    logic [31:0]       addr_reg, size_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, peak_reg;
    logic [31:0]       free_reg, lost_cnt_reg, lost_bytes_reg;
    logic [31:0]       res_reg;
    logic [1:0]        st_reg;
    logic              prev_ok_reg;
    logic [31:0]       prev_s_reg, prev_l_reg;
    logic              ins_reg;   // shift direction: 1 up (insert), 0 down
    logic [CNT_W-1:0]  stop_reg;
    logic [ENTRY_W-1:0] hold_reg;

    logic              we_reg;
    logic [IDX_W-1:0]  waddr_reg, raddr;
    logic [ENTRY_W-1:0] wdata_reg, rdata;
    logic [31:0]       cur_s, cur_l;

    ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
        .aclk(aclk), .we(we_reg), .waddr(waddr_reg), .wdata(wdata_reg),
        .raddr(raddr), .rdata(rdata)
    );

    assign cur_s = rdata[31:0];
    assign cur_l = rdata[63:32];
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = st_reg;
    assign m_tdata  = {6'b0, lost_bytes_reg, lost_cnt_reg, peak_reg, count_reg,
                       free_reg, res_reg};

    // read address: the entry the scan or shift needs next
    always_comb begin
        raddr = idx_reg[IDX_W-1:0];
        if (state_reg == S_SHRD) begin
            raddr = ins_reg ? IDX_W'(idx_reg - 1'b1) : IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            peak_reg       <= '0;
            free_reg       <= '0;
            lost_cnt_reg   <= '0;
            lost_bytes_reg <= '0;
            we_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            we_reg    <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= s_tuser;
                        addr_reg    <= s_tdata[31:0];
                        size_reg    <= s_tdata[63:32];
                        prev_ok_reg <= 1'b0;
                        res_reg     <= '0;
                        st_reg      <= ST_OK;
                    end
                end
                S_EVAL: begin
                    if (op_reg == OP_ALLOC) begin
                        if (idx_reg == count_reg) begin
                            st_reg <= ST_NOFIT;
                        end else if (cur_l >= size_reg) begin
                            res_reg  <= cur_s;
                            free_reg <= free_reg - size_reg;
                            if (cur_l == size_reg) begin
                                ins_reg  <= 1'b0;
                                stop_reg <= count_reg - 1'b1;
                                count_reg <= count_reg - 1'b1;
                            end else begin
                                we_reg    <= 1'b1;
                                waddr_reg <= idx_reg[IDX_W-1:0];
                                wdata_reg <= {cur_l - size_reg, cur_s + size_reg};
                            end
                        end
                    end else if (idx_reg == count_reg || cur_s > addr_reg) begin
                        if (prev_ok_reg && prev_s_reg + prev_l_reg == addr_reg) begin
                            free_reg  <= free_reg + size_reg;
                            we_reg    <= 1'b1;
                            waddr_reg <= IDX_W'(idx_reg - 1'b1);
                            if (idx_reg != count_reg
                                && addr_reg + size_reg == cur_s) begin
                                wdata_reg <= {prev_l_reg + size_reg + cur_l, prev_s_reg};
                                ins_reg  <= 1'b0;
                                stop_reg <= count_reg - 1'b1;
                                count_reg <= count_reg - 1'b1;
                            end else begin
                                wdata_reg <= {prev_l_reg + size_reg, prev_s_reg};
                            end
                        end else if (idx_reg != count_reg
                                     && addr_reg + size_reg == cur_s) begin
                            free_reg  <= free_reg + size_reg;
                            we_reg    <= 1'b1;
                            waddr_reg <= idx_reg[IDX_W-1:0];
                            wdata_reg <= {cur_l + size_reg, addr_reg};
                        end else if (count_reg < CNT_W'(TABLE_ENTRIES)) begin
                            free_reg  <= free_reg + size_reg;
                            ins_reg   <= 1'b1;
                            stop_reg  <= idx_reg;
                            count_reg <= count_reg + 1'b1;
                            if (peak_reg < count_reg + 1'b1) begin
                                peak_reg <= count_reg + 1'b1;
                            end
                            hold_reg <= {size_reg, addr_reg};
                        end else begin
                            st_reg <= ST_LOST;
                            lost_cnt_reg <= (&lost_cnt_reg) ? lost_cnt_reg
                                                            : lost_cnt_reg + 1'b1;
                            lost_bytes_reg <= (lost_bytes_reg + size_reg < lost_bytes_reg)
                                              ? 32'hFFFF_FFFF
                                              : lost_bytes_reg + size_reg;
                        end
                    end else begin
                        prev_ok_reg <= 1'b1;
                        prev_s_reg  <= cur_s;
                        prev_l_reg  <= cur_l;
                    end
                end
                S_SHWR: begin
                    we_reg    <= 1'b1;
                    waddr_reg <= idx_reg[IDX_W-1:0];
                    wdata_reg <= rdata;
                end
                S_FIN: begin
                    we_reg    <= 1'b1;
                    waddr_reg <= idx_reg[IDX_W-1:0];
                    wdata_reg <= hold_reg;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (s_tvalid) state_next = S_READ;
            end
            S_READ: state_next = S_EVAL;
            S_EVAL: begin
                state_next = S_OUT;
                if (op_reg == OP_ALLOC) begin
                    if (idx_reg != count_reg) begin
                        if (cur_l >= size_reg) begin
                            if (cur_l == size_reg) begin
                                state_next = S_NEXT;
                            end
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                end else if (idx_reg == count_reg || cur_s > addr_reg) begin
                    if (prev_ok_reg && prev_s_reg + prev_l_reg == addr_reg) begin
                        if (idx_reg != count_reg && addr_reg + size_reg == cur_s) begin
                            state_next = S_NEXT;
                        end
                    end else if (idx_reg != count_reg
                                 && addr_reg + size_reg == cur_s) begin
                        state_next = S_OUT;
                    end else if (count_reg < CNT_W'(TABLE_ENTRIES)) begin
                        idx_next   = count_reg;
                        state_next = S_NEXT;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_NEXT: begin
                // remove: entries idx..stop-1 take idx+1; insert: count..stop+1
                if (idx_reg == stop_reg) begin
                    state_next = ins_reg ? S_FIN : S_OUT;
                end else begin
                    state_next = S_SHRD;
                end
            end
            S_SHRD: state_next = S_SHWR;
            S_SHWR: begin
                idx_next   = ins_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                state_next = S_NEXT;
            end
            S_FIN: state_next = S_OUT;
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES)) else $error("count overflow");
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= count_reg) else $error("peak below count");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    a_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_LOST) |-> count_reg == CNT_W'(TABLE_ENTRIES))
        else $error("lost with room");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release requests into the free-list allocator, keeps
// its own sorted free-region table and checks every result field.
// ----------------------------------------------------------------------------
module testbench;
    import ffa_pkg::*;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
        logic [31:0] free_total;
        logic [8:0]  entries_used;
        logic [8:0]  peak_entries;
        logic [31:0] lost_count;
        logic [31:0] lost_bytes;
    } alloc_result_t;

    class alloc_scoreboard;
        logic [31:0]   reg_start[$];
        logic [31:0]   reg_len[$];
        logic [8:0]    peak;
        logic [31:0]   lost_n;
        logic [31:0]   lost_b;
        logic [31:0]   free_sum;
        alloc_result_t pending[$];
        int            errors;

        function new();
            peak = 0; lost_n = 0; lost_b = 0; free_sum = 0; errors = 0;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = a + b;
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void note_request(logic op, logic [31:0] addr, logic [31:0] size);
            alloc_result_t r;
            int i;
            int n;
            bit done;
            r = '0;
            r.status = ST_OK;
            n = reg_start.size();
            if (op == OP_ALLOC) begin
                done = 0;
                for (i = 0; i < n && !done; i++) begin
                    if (reg_len[i] >= size) begin
                        r.result_addr = reg_start[i];
                        reg_start[i] += size;
                        reg_len[i] -= size;
                        free_sum -= size;
                        if (reg_len[i] == 0) begin
                            reg_start.delete(i);
                            reg_len.delete(i);
                        end
                        done = 1;
                    end
                end
                if (!done) r.status = ST_NOFIT;
            end else begin
                for (i = 0; i < n; i++)
                    if (reg_start[i] > addr) break;
                if (i > 0 && reg_start[i-1] + reg_len[i-1] == addr) begin
                    reg_len[i-1] += size;
                    free_sum += size;
                    if (i < n && addr + size == reg_start[i]) begin
                        reg_len[i-1] += reg_len[i];
                        reg_start.delete(i);
                        reg_len.delete(i);
                    end
                end else if (i < n && addr + size == reg_start[i]) begin
                    reg_start[i] = addr;
                    reg_len[i] += size;
                    free_sum += size;
                end else if (n < TABLE_ENTRIES) begin
                    reg_start.insert(i, addr);
                    reg_len.insert(i, size);
                    free_sum += size;
                    if (peak < n + 1) peak = 9'(n + 1);
                end else begin
                    lost_n = sat_add(lost_n, 32'd1);
                    lost_b = sat_add(lost_b, size);
                    r.status = ST_LOST;
                end
            end
            r.free_total   = free_sum;
            r.entries_used = 9'(reg_start.size());
            r.peak_entries = peak;
            r.lost_count   = lost_n;
            r.lost_bytes   = lost_b;
            pending.push_back(r);
        endfunction

        function void check_result(alloc_result_t a);
            alloc_result_t e;
            if (pending.size() == 0) begin
                $error("result with none expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.result_addr !== e.result_addr) begin
                $error("result_addr exp %h got %h", e.result_addr, a.result_addr);
                errors++;
            end
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.free_total !== e.free_total) begin
                $error("free_total exp %h got %h", e.free_total, a.free_total); errors++;
            end
            if (a.entries_used !== e.entries_used) begin
                $error("entries_used exp %0d got %0d", e.entries_used, a.entries_used);
                errors++;
            end
            if (a.peak_entries !== e.peak_entries) begin
                $error("peak_entries exp %0d got %0d", e.peak_entries, a.peak_entries);
                errors++;
            end
            if (a.lost_count !== e.lost_count) begin
                $error("lost_count exp %h got %h", e.lost_count, a.lost_count); errors++;
            end
            if (a.lost_bytes !== e.lost_bytes) begin
                $error("lost_bytes exp %h got %h", e.lost_bytes, a.lost_bytes); errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;

    int src_idle = 0;
    int sink_idle = 0;
    longint cycles = 0;
    bit stim_done = 0;
    alloc_scoreboard sb;

    localparam longint CYCLE_LIMIT = 4_000_000;

    first_fit_free_list_allocator dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        alloc_result_t r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            r.result_addr  = m_tdata[31:0];
            r.free_total   = m_tdata[63:32];
            r.entries_used = m_tdata[72:64];
            r.peak_entries = m_tdata[81:73];
            r.lost_count   = m_tdata[113:82];
            r.lost_bytes   = m_tdata[145:114];
            r.status       = m_tuser;
            sb.check_result(r);
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    task automatic send_request(logic op, logic [31:0] addr, logic [31:0] size);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {size, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(op, addr, size);
        @(negedge aclk);
    endtask

    // addresses kept in a coarse grid so releases meet neighbors often
    task automatic random_request();
        logic [31:0] a;
        logic [31:0] s;
        int k;
        k = $urandom_range(99);
        a = $urandom_range(511) * 16;
        s = $urandom_range(1, 8) * 16;
        if (k < 5) begin
            a = $urandom; s = $urandom;
        end else if (k < 10) begin
            s = $urandom_range(15);
        end
        if ($urandom_range(1)) send_request(OP_RELEASE, a, s);
        else send_request(OP_ALLOC, $urandom, (k < 8) ? $urandom : s);
    endtask

    initial begin
        int i;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: empty table, zero sizes, merges, wrap, extremes
        send_request(OP_ALLOC, 32'h0, 32'h0);
        send_request(OP_RELEASE, 32'h0, 32'h0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_RELEASE, 32'h100, 32'h100);
        send_request(OP_RELEASE, 32'h300, 32'h100);
        send_request(OP_RELEASE, 32'h200, 32'h100);
        send_request(OP_RELEASE, 32'h0, 32'h100);
        send_request(OP_ALLOC, 32'h0, 32'h80);
        send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'h0, 32'h380);
        send_request(OP_RELEASE, 32'hFFFF_FF00, 32'h100);
        send_request(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_RELEASE, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_ALLOC, 32'h0, 32'h0);
        send_request(OP_ALLOC, 32'h0, 32'h10);
        send_request(OP_RELEASE, 32'h5555_5555, 32'hAAAA_AAAA);
        send_request(OP_RELEASE, 32'hAAAA_AAAA, 32'h5555_5555);

        // fill the table past capacity, then drop releases with saturation
        for (i = 0; i < 258; i++)
            send_request(OP_RELEASE, 32'h1000_0000 + i * 64, 32'h20);
        send_request(OP_RELEASE, 32'h7000_0001, 32'hFFFF_FFFF);
        send_request(OP_RELEASE, 32'h7000_0100, 32'hFFFF_FFFF);
        for (i = 0; i < 30; i++)
            send_request(OP_ALLOC, $urandom, $urandom_range(2) * 16);

        src_idle = 26; sink_idle = 45;
        for (i = 0; i < 48; i++) random_request();
        src_idle = 45; sink_idle = 26;
        for (i = 0; i < 48; i++) random_request();
        src_idle = 0; sink_idle = 0;
        for (i = 0; i < 48; i++) random_request();
        s_tvalid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/first_fit_free_list_allocator.sv
dv/testbench.sv
